### rtl/twm_pkg.sv
// Shared types and constants for the windowed throughput meter.
`default_nettype none

package twm_pkg;

    // Widths of the arithmetic datapath.
    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_CNT_W = 6;

    // Reset value of the update interval register, in nanoseconds.
    localparam logic [31:0] INTERVAL_RESET = 32'd500000000;

    // Scale factor that turns nanoseconds into 1/1024-second units after a >> 32.
    localparam logic [12:0] MISECS_FACTOR = 13'd4398;

    // Register indexes on the configuration port.
    localparam logic REG_UPDATE_INTERVAL = 1'b0;

    // One input sample.
    typedef struct packed {
        logic [47:0] total_bytes;
        logic [63:0] now_ns;
    } in_t;

    // One result.
    typedef struct packed {
        logic        rate_updated;
        logic [31:0] rate_kib_per_s;
        logic [31:0] mean_rate_kib_per_s;
    } out_t;

endpackage

`default_nettype wire

### rtl/windowed_throughput_meter_top.sv
// Windowed throughput meter: sample sequencer, window memory and two dividers.
// Sequence: a first sample goes from idle straight to output, an ignored sample passes
// through compare, and a counted sample through compare, multiply, sum and 32 divide steps.
// One sample at a time: a new request is taken only once the result has been registered;
// the bit-serial dividers run in parallel for the windowed and the mean rate.
// Reset: asynchronous, active low; the window slots read as zero through per-slot valid bits.
`default_nettype none

module windowed_throughput_meter_top #(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    // Sample channel.
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire twm_pkg::in_t  in_data,
    // Result channel.
    output logic               out_valid,
    input  wire logic          out_ready,
    output twm_pkg::out_t      out_data,
    // Configuration port.
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CMP  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    started_reg, started_next;
    logic [31:0]             last_total_reg, last_total_next;
    logic [63:0]             last_time_reg, last_time_next;
    logic [31:0]             byte_sum_reg, byte_sum_next;
    logic [31:0]             time_sum_reg, time_sum_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic [31:0]             mean_reg, mean_next;
    logic [31:0]             interval_reg, interval_next;
    logic                    out_valid_reg, out_valid_next;
    twm_pkg::out_t           out_data_reg, out_data_next;

    logic [31:0]             total_lo_reg, total_lo_next;
    logic [63:0]             now_reg, now_next;
    logic [63:0]             dt_reg, dt_next;
    logic [31:0]             count_reg, count_next;
    logic [44:0]             prod_lo_reg, prod_lo_next;
    logic [31:0]             prod_hi_reg, prod_hi_next;
    logic [31:0]             misecs_reg, misecs_next;
    logic [31:0]             bsum_new_reg, bsum_new_next;
    logic [31:0]             tsum_new_reg, tsum_new_next;
    twm_pkg::out_t           res_reg, res_next;

    logic                    cfg_write;
    logic                    ram_we;
    logic [63:0]             ram_rdata;
    logic [31:0]             old_bytes;
    logic [31:0]             old_time;
    logic [31:0]             mean_bytes;
    logic [31:0]             mean_time;
    logic                    div_start;
    logic                    rate_done;
    logic                    mean_done;
    logic [31:0]             rate_quo;
    logic [31:0]             mean_quo;
    logic [31:0]             misecs_sum;

    // Configuration port: zero-wait APB, one register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == twm_pkg::REG_UPDATE_INTERVAL) ? interval_reg : '0;

    // Window memory: byte count in the upper half, time in the lower half.
    twm_ram #(
        .WIDTH (64),
        .DEPTH (WINDOW_DEPTH),
        .ADDR_W(SLOT_W)
    ) u_window (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_reg),
        .wdata({count_reg, misecs_reg}),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    // Slot contents; a slot never written since reset reads as zero.
    assign old_bytes  = valid_reg[slot_reg] ? ram_rdata[63:32] : '0;
    assign old_time   = valid_reg[slot_reg] ? ram_rdata[31:0] : '0;
    assign mean_bytes = bsum_new_reg - old_bytes;
    assign mean_time  = tsum_new_reg - old_time;
    assign misecs_sum = prod_hi_reg + 32'(prod_lo_reg[44:32]);
    assign div_start  = (state_reg == ST_SUM);
    assign ram_we     = (state_reg == ST_SUM);

    // Windowed rate before the oldest slot leaves.
    twm_div u_rate_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (bsum_new_reg),
        .den  (tsum_new_reg),
        .done (rate_done),
        .quo  (rate_quo)
    );

    // Mean rate after the oldest slot leaves.
    twm_div u_mean_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (mean_bytes),
        .den  (mean_time),
        .done (mean_done),
        .quo  (mean_quo)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sample sequencer.
    always_comb
    begin
        state_next      = state_reg;
        started_next    = started_reg;
        last_total_next = last_total_reg;
        last_time_next  = last_time_reg;
        byte_sum_next   = byte_sum_reg;
        time_sum_next   = time_sum_reg;
        slot_next       = slot_reg;
        valid_next      = valid_reg;
        mean_next       = mean_reg;
        interval_next   = interval_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        total_lo_next   = total_lo_reg;
        now_next        = now_reg;
        dt_next         = dt_reg;
        count_next      = count_reg;
        prod_lo_next    = prod_lo_reg;
        prod_hi_next    = prod_hi_reg;
        misecs_next     = misecs_reg;
        bsum_new_next   = bsum_new_reg;
        tsum_new_next   = tsum_new_reg;
        res_next        = res_reg;

        if (cfg_write && (paddr[2] == twm_pkg::REG_UPDATE_INTERVAL))
        begin
            interval_next = pwdata;
        end

        // The result register empties when the consumer takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    total_lo_next = in_data.total_bytes[31:0];
                    now_next      = in_data.now_ns;
                    dt_next       = in_data.now_ns - last_time_reg;
                    if (!started_reg)
                    begin
                        // First sample only records the baseline.
                        started_next                 = 1'b1;
                        last_total_next              = in_data.total_bytes[31:0];
                        last_time_next               = in_data.now_ns;
                        res_next.rate_updated        = 1'b0;
                        res_next.rate_kib_per_s      = '0;
                        res_next.mean_rate_kib_per_s = mean_reg;
                        state_next                   = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                count_next   = total_lo_reg - last_total_reg;
                prod_lo_next = 45'(dt_reg[31:0]) * 45'(twm_pkg::MISECS_FACTOR);
                prod_hi_next = dt_reg[63:32] * 32'(twm_pkg::MISECS_FACTOR);
                if (dt_reg > {32'd0, interval_reg})
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    res_next.rate_updated        = 1'b0;
                    res_next.rate_kib_per_s      = '0;
                    res_next.mean_rate_kib_per_s = mean_reg;
                    state_next                   = ST_OUT;
                end
            end
            ST_MUL:
            begin
                misecs_next   = misecs_sum;
                bsum_new_next = byte_sum_reg + count_reg;
                tsum_new_next = time_sum_reg + misecs_sum;
                state_next    = ST_SUM;
            end
            ST_SUM:
            begin
                // Retire the oldest slot and store the new one in its place.
                byte_sum_next        = mean_bytes;
                time_sum_next        = mean_time;
                valid_next[slot_reg] = 1'b1;
                slot_next            = (slot_reg == SLOT_W'(WINDOW_DEPTH - 1)) ?
                                       '0 : slot_reg + 1'b1;
                last_total_next      = total_lo_reg;
                last_time_next       = now_reg;
                state_next           = ST_DIV;
            end
            ST_DIV:
            begin
                if (rate_done)
                begin
                    res_next.rate_updated        = 1'b1;
                    res_next.rate_kib_per_s      = rate_quo;
                    res_next.mean_rate_kib_per_s = mean_quo;
                    mean_next                    = mean_quo;
                    state_next                   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            started_reg    <= 1'b0;
            last_total_reg <= '0;
            last_time_reg  <= '0;
            byte_sum_reg   <= '0;
            time_sum_reg   <= '0;
            slot_reg       <= '0;
            valid_reg      <= '0;
            mean_reg       <= '0;
            interval_reg   <= twm_pkg::INTERVAL_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            started_reg    <= started_next;
            last_total_reg <= last_total_next;
            last_time_reg  <= last_time_next;
            byte_sum_reg   <= byte_sum_next;
            time_sum_reg   <= time_sum_next;
            slot_reg       <= slot_next;
            valid_reg      <= valid_next;
            mean_reg       <= mean_next;
            interval_reg   <= interval_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        total_lo_reg <= total_lo_next;
        now_reg      <= now_next;
        dt_reg       <= dt_next;
        count_reg    <= count_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        misecs_reg   <= misecs_next;
        bsum_new_reg <= bsum_new_next;
        tsum_new_reg <= tsum_new_next;
        res_reg      <= res_next;
    end

`ifndef NO_ASSERTIONS
    // Both dividers start together and must finish together.
    assert property (@(posedge clk) disable iff (!rst_n) rate_done |-> mean_done)
        else $error("rate and mean dividers finished out of step");

    // A result without an update carries no windowed rate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.rate_updated) |-> (out_data_reg.rate_kib_per_s == '0))
        else $error("rate reported on a sample that did not update");

    // Every slot write advances the slot pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> ((slot_reg != $past(slot_reg)) || (WINDOW_DEPTH == 1)))
        else $error("slot pointer did not advance after a window write");

    // Once the baseline is recorded it stays recorded.
    assert property (@(posedge clk) disable iff (!rst_n) started_reg |=> started_reg)
        else $error("started flag dropped without reset");
`endif

endmodule

`default_nettype wire

### rtl/twm_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none

module twm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/twm_div.sv
// Restoring 32-bit unsigned divider, one quotient bit per cycle, zero on a zero divisor.
`default_nettype none

module twm_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [twm_pkg::DATA_W-1:0] num,
    input  wire logic [twm_pkg::DATA_W-1:0] den,
    output logic                          done,
    output logic [twm_pkg::DATA_W-1:0]    quo
);

    localparam int unsigned W = twm_pkg::DATA_W;

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [twm_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    quo_reg, quo_next;
    logic [W-1:0]                    den_reg, den_next;
    logic                            den_zero_reg, den_zero_next;
    logic [W:0]                      shifted;
    logic [W:0]                      diff;
    logic                            fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});

        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        den_zero_next = den_zero_reg;

        if (start)
        begin
            busy_next     = 1'b1;
            cnt_next      = twm_pkg::DIV_CNT_W'(W);
            rem_next      = '0;
            quo_next      = num;
            den_next      = den;
            den_zero_next = (den == '0);
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == twm_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        den_zero_reg <= den_zero_next;
    end

    assign done = done_reg;
    assign quo  = den_zero_reg ? '0 : quo_reg;

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for the windowed throughput meter top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int WINDOW_SLOTS = 8;
    localparam int MAX_REPORTS = 100;
    localparam logic [2:0] INTERVAL_ADDR = 3'(4 * int'(twm_pkg::REG_UPDATE_INTERVAL));
    localparam logic [2:0] UNUSED_ADDR = 3'(4 * (int'(twm_pkg::REG_UPDATE_INTERVAL) + 1));
    localparam logic [63:0] NS_TO_MISECS = 64'(twm_pkg::MISECS_FACTOR);

    // Shapes of random samples.
    typedef enum int {
        SAMPLE_COUNTED,
        SAMPLE_SHORT,
        SAMPLE_NOISE,
        SAMPLE_TIME_BACK,
        SAMPLE_BYTES_BACK
    } sample_kind_e;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    twm_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    twm_pkg::out_t out_data;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [2:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    // Predicted meter state and configuration.
    logic [31:0] interval_ns;
    logic        meter_started;
    logic [47:0] recorded_total;
    logic [63:0] recorded_time;
    logic [31:0] byte_sum;
    logic [31:0] time_sum;
    logic [31:0] byte_slots [WINDOW_SLOTS];
    logic [31:0] time_slots [WINDOW_SLOTS];
    logic [2:0]  slot_ptr;

    // Expected results in request order.
    twm_pkg::out_t rate_queue [$];

    // Last sample sent, used to build the next one.
    logic [47:0] sent_total;
    logic [63:0] sent_time;

    int source_idle_pct;
    int sink_idle_pct;
    int cycle_count;
    int mismatch_count;

    windowed_throughput_meter_top #(
        .WINDOW_DEPTH(WINDOW_SLOTS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Free-running clock.
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] safe_div(input logic [31:0] num, input logic [31:0] den);
        return (den == 32'd0) ? 32'd0 : num / den;
    endfunction

    // Advance the predicted meter by one sample and return the result it gives.
    function automatic twm_pkg::out_t compute_rate(input twm_pkg::in_t smp);
        logic [63:0]   dt;
        logic [63:0]   scaled;
        logic [47:0]   delta;
        logic [31:0]   misecs;
        logic [31:0]   count;
        twm_pkg::out_t res;
        res = '0;
        if (!meter_started)
        begin
            meter_started = 1'b1;
            recorded_total = smp.total_bytes;
            recorded_time = smp.now_ns;
        end
        else
        begin
            dt = smp.now_ns - recorded_time;
            if (dt > {32'd0, interval_ns})
            begin
                // Elapsed time in 1/1024 s units; the product wraps at 64 bits.
                scaled = dt * NS_TO_MISECS;
                misecs = scaled[63:32];
                delta = smp.total_bytes - recorded_total;
                count = delta[31:0];
                recorded_total = smp.total_bytes;
                recorded_time = smp.now_ns;
                byte_sum = byte_sum + count;
                time_sum = time_sum + misecs;
                res.rate_updated = 1'b1;
                res.rate_kib_per_s = safe_div(byte_sum, time_sum);
                // Retire the oldest slot and store the new interval in its place.
                byte_sum = byte_sum - byte_slots[slot_ptr];
                time_sum = time_sum - time_slots[slot_ptr];
                byte_slots[slot_ptr] = count;
                time_slots[slot_ptr] = misecs;
                slot_ptr = slot_ptr + 3'd1;
            end
        end
        res.mean_rate_kib_per_s = safe_div(byte_sum, time_sum);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_REPORTS)
            $display("MISMATCH cycle %0d: %s got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Result checker; also stalls the result channel at random.
    always @(posedge clk)
    begin : result_check
        twm_pkg::out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (rate_queue.size() == 0)
                    report_mismatch("result with no request pending",
                                    out_data.rate_kib_per_s, 32'd0);
                else
                begin
                    want = rate_queue.pop_front();
                    if (out_data.rate_updated !== want.rate_updated)
                        report_mismatch("rate_updated", 32'(out_data.rate_updated),
                                        32'(want.rate_updated));
                    if (out_data.rate_kib_per_s !== want.rate_kib_per_s)
                        report_mismatch("rate_kib_per_s", out_data.rate_kib_per_s,
                                        want.rate_kib_per_s);
                    if (out_data.mean_rate_kib_per_s !== want.mean_rate_kib_per_s)
                        report_mismatch("mean_rate_kib_per_s", out_data.mean_rate_kib_per_s,
                                        want.mean_rate_kib_per_s);
                end
            end
            out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Send one sample request and record its expected result once accepted.
    task automatic send_sample(input logic [47:0] total, input logic [63:0] now);
        twm_pkg::in_t smp;
        smp.total_bytes = total;
        smp.now_ns = now;
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= smp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rate_queue.push_back(compute_rate(smp));
        sent_total = total;
        sent_time = now;
    endtask

    // Stop sending and wait for every expected result.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (rate_queue.size() != 0)
            @(posedge clk);
    endtask

    // Read the interval register and compare it with the predicted value.
    task automatic read_interval_check();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= INTERVAL_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== interval_ns)
            report_mismatch("update_interval_ns readback", prdata, interval_ns);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write a register once the meter is idle, then read the interval back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == INTERVAL_ADDR)
            interval_ns = value;
        read_interval_check();
    endtask

    // Reset value, first sample, boundaries, wraps and sum overflow.
    task automatic test_directed();
        read_interval_check();
        send_sample(48'd0, 64'd0);
        send_sample(48'd100, 64'd500_000_000);
        send_sample(48'd1000, 64'd500_000_001);
        send_sample(48'hFFFF_FFFF_FFFF, 64'd2_000_000_000);
        send_sample(48'd5, 64'd3_000_000_000);
        send_sample(48'h10_0000, 64'd1_000_000_000);
        send_sample(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_sample(48'd0, 64'd0);
        send_sample(48'h8000_0000_0000, 64'h8000_0000_0000_0000);
        send_sample(48'h8000_1000_0000, 64'h8000_0000_4000_0000);
        send_sample(48'h8000_1000_0001, 64'h8000_0000_400F_4240);
        // Large byte deltas make the byte sum wrap.
        for (int n = 0; n < 4; n++)
            send_sample(sent_total + 48'hF000_0000, sent_time + 64'd1_000_000_000);
    endtask

    // A write to an address with no register must leave the interval alone.
    task automatic test_unknown_register();
        write_register(UNUSED_ADDR, 32'h0000_1234);
    endtask

    // Intervals too short to reach one time unit drive the divisor to zero.
    task automatic test_zero_divisor();
        write_register(INTERVAL_ADDR, 32'd0);
        send_sample(sent_total, sent_time);
        for (int n = 0; n < 12; n++)
            send_sample(sent_total + 48'($urandom_range(0, 5000)),
                        sent_time + 64'($urandom_range(1, 900_000)));
    endtask

    // Mostly well-formed sample sequences, with noise and backward steps mixed in.
    task automatic test_random_samples(input logic [31:0] interval, input int count,
                                       input int idle_pct);
        sample_kind_e kind;
        int           pick;
        logic [47:0]  grow;
        logic [63:0]  long_gap;
        write_register(INTERVAL_ADDR, interval);
        source_idle_pct = idle_pct;
        sink_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            // Halfway through, hold off until every expected result is back.
            if (n == count / 2)
                wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                kind = SAMPLE_COUNTED;
            else if (pick < 80)
                kind = SAMPLE_SHORT;
            else if (pick < 90)
                kind = SAMPLE_NOISE;
            else if (pick < 95)
                kind = SAMPLE_TIME_BACK;
            else
                kind = SAMPLE_BYTES_BACK;
            if ($urandom_range(0, 9) == 0)
                grow = {16'($urandom), 32'($urandom)};
            else
                grow = 48'($urandom_range(0, 32'h40_0000));
            long_gap = 64'(interval) + 64'd1 + 64'($urandom_range(0, 2_000_000_000));
            case (kind)
                SAMPLE_COUNTED:
                    send_sample(sent_total + grow, sent_time + long_gap);
                SAMPLE_SHORT:
                    send_sample(sent_total + grow, sent_time + 64'($urandom_range(0, interval)));
                SAMPLE_NOISE:
                    send_sample({16'($urandom), 32'($urandom)}, {$urandom, $urandom});
                SAMPLE_TIME_BACK:
                    send_sample(sent_total + grow,
                                sent_time - 64'($urandom_range(1, 32'hFFFF_FFFF)));
                SAMPLE_BYTES_BACK:
                    send_sample(sent_total - grow, sent_time + long_gap);
                default:
                    send_sample(sent_total, sent_time);
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycle_count = 0;
        mismatch_count = 0;
        source_idle_pct = 34;
        sink_idle_pct = 34;
        sent_total = '0;
        sent_time = '0;

        // Predicted state after reset.
        interval_ns = twm_pkg::INTERVAL_RESET;
        meter_started = 1'b0;
        recorded_total = '0;
        recorded_time = '0;
        byte_sum = '0;
        time_sum = '0;
        slot_ptr = '0;
        for (int i = 0; i < WINDOW_SLOTS; i++)
        begin
            byte_slots[i] = '0;
            time_slots[i] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_unknown_register();
        test_zero_divisor();
        test_random_samples(twm_pkg::INTERVAL_RESET, 300, 34);
        test_random_samples(32'd0, 250, 34);
        test_random_samples(32'hFFFF_FFFF, 250, 34);
        test_random_samples($urandom, 250, 0);
        test_random_samples(32'd1_000_000, 200, 34);
        test_random_samples($urandom_range(1, 5_000_000), 170, 34);

        // Let the last results arrive, then allow for any trailing activity.
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### windowed_throughput_meter_top.f
rtl/twm_pkg.sv
rtl/twm_ram.sv
rtl/twm_div.sv
rtl/windowed_throughput_meter_top.sv
sim/tb_top.sv
